>>> rtl/bpmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmp_pkg
// Types, codes and the type-name table shared by the brace pair message
// parser and its checker.
// ----------------------------------------------------------------------------
package bpmp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_OPEN    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_VALUE   = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_VALUE  = 3'd1;
  localparam logic [2:0] ST_CLOSED = 3'd2;
  localparam logic [2:0] ST_ACCEPT = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_BRACE = 3'd1;
  localparam logic [2:0] ERR_END   = 3'd2;
  localparam logic [2:0] ERR_TYPE  = 3'd3;
  localparam logic [2:0] ERR_LONG  = 3'd4;

  // framing characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  // type names: caller, callee, define, use, lang
  localparam int NUM_TYPES = 5;
  localparam int NAME_MAX = 6;
  localparam logic [4:0] ALL_TYPES = 5'h1F;
  localparam logic [2:0] TYPE_LEN_MAX = 3'd7;
  localparam logic [9:0] VALUE_LIMIT_RESET = 10'd1023;

  localparam logic [2:0] TYPE_LENS [NUM_TYPES] = '{3'd6, 3'd6, 3'd6, 3'd3, 3'd4};

  localparam logic [7:0] NAME_CHARS [NUM_TYPES][NAME_MAX] = '{
    '{8'h63, 8'h61, 8'h6C, 8'h6C, 8'h65, 8'h72},  // caller
    '{8'h63, 8'h61, 8'h6C, 8'h6C, 8'h65, 8'h65},  // callee
    '{8'h64, 8'h65, 8'h66, 8'h69, 8'h6E, 8'h65},  // define
    '{8'h75, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},  // use
    '{8'h6C, 8'h61, 8'h6E, 8'h67, 8'h00, 8'h00}   // lang
  };

  // character of a type name at a position, zero past the table
  function automatic logic [7:0] name_char(input int unsigned t, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (t < NUM_TYPES && pos < 3'(NAME_MAX)) begin
      c = NAME_CHARS[t][pos];
    end
    return c;
  endfunction

  // per-pair parser state, value length kept apart since its width varies
  typedef struct packed {
    phase_t     phase;
    logic [4:0] cand_mask;
    logic [2:0] type_len;
    logic [2:0] cur_type;
  } pair_state_t;

  // one result item
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_byte;
    logic [2:0] type_code;
    logic [2:0] error_kind;
  } result_t;

endpackage

>>> rtl/bpmp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmp channel interfaces
// Valid/ready channels for message bytes, results and the limit register.
// ----------------------------------------------------------------------------

// message byte channel
interface bpmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  modport source (output valid, output msg_byte, input ready);
  modport sink   (input valid, input msg_byte, output ready);
endinterface

// result channel
interface bpmp_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_byte;
  logic [2:0] type_code;
  logic [2:0] error_kind;
  modport source (output valid, output status, output data_byte, output type_code,
                  output error_kind, input ready);
  modport sink   (input valid, input status, input data_byte, input type_code,
                  input error_kind, output ready);
endinterface

// configuration write channel
interface bpmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] value_limit;
  modport source (output valid, output value_limit, input ready);
  modport sink   (input valid, input value_limit, output ready);
endinterface

>>> rtl/bpmp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmp_core
// One parser step: current pair state and one byte give the next state and
// the result item. Purely combinational.
// ----------------------------------------------------------------------------
module bpmp_core #(
  parameter int VLEN_W = 10
) (
  input  bpmp_pkg::pair_state_t state,
  input  logic [VLEN_W-1:0]     value_length,
  input  logic [7:0]            msg_byte,
  input  logic [9:0]            limit,
  output bpmp_pkg::pair_state_t state_next,
  output logic [VLEN_W-1:0]     value_length_next,
  output bpmp_pkg::result_t     result
);

  logic [4:0] mask_step;
  logic       found;
  logic [2:0] found_type;
  logic       too_long;

  // candidate update for a type character
  always_comb begin
    for (int i = 0; i < bpmp_pkg::NUM_TYPES; i++) begin
      mask_step[i] = state.cand_mask[i] && (state.type_len < bpmp_pkg::TYPE_LENS[i]) &&
                     (bpmp_pkg::name_char(i, state.type_len) == msg_byte);
    end
  end

  // first full-length candidate at the colon
  always_comb begin
    found      = 1'b0;
    found_type = 3'd0;
    for (int i = 0; i < bpmp_pkg::NUM_TYPES; i++) begin
      if (!found && state.cand_mask[i] && bpmp_pkg::TYPE_LENS[i] == state.type_len) begin
        found      = 1'b1;
        found_type = 3'(i);
      end
    end
  end

  assign too_long = 10'(value_length) >= limit;

  // next state
  always_comb begin
    state_next        = state;
    value_length_next = value_length;
    case (state.phase)
      bpmp_pkg::PH_OPEN: begin
        state_next.cand_mask = bpmp_pkg::ALL_TYPES;
        state_next.type_len  = 3'd0;
        state_next.cur_type  = 3'd0;
        value_length_next    = '0;
        if (msg_byte == bpmp_pkg::CH_NUL) begin
          state_next.phase = bpmp_pkg::PH_OPEN;
        end else if (msg_byte == bpmp_pkg::CH_OPEN) begin
          state_next.phase = bpmp_pkg::PH_TYPE;
        end else begin
          state_next.phase = bpmp_pkg::PH_DISCARD;
        end
      end
      bpmp_pkg::PH_TYPE: begin
        if (msg_byte == bpmp_pkg::CH_NUL) begin
          state_next.phase     = bpmp_pkg::PH_OPEN;
          state_next.cand_mask = bpmp_pkg::ALL_TYPES;
          state_next.type_len  = 3'd0;
          state_next.cur_type  = 3'd0;
          value_length_next    = '0;
        end else if (msg_byte == bpmp_pkg::CH_COLON) begin
          if (found) begin
            state_next.phase    = bpmp_pkg::PH_VALUE;
            state_next.cur_type = found_type;
            value_length_next   = '0;
          end else begin
            state_next.phase = bpmp_pkg::PH_DISCARD;
          end
        end else begin
          state_next.cand_mask = mask_step;
          if (state.type_len < bpmp_pkg::TYPE_LEN_MAX) begin
            state_next.type_len = state.type_len + 3'd1;
          end
        end
      end
      bpmp_pkg::PH_VALUE: begin
        if (msg_byte == bpmp_pkg::CH_NUL || msg_byte == bpmp_pkg::CH_CLOSE) begin
          state_next.phase     = bpmp_pkg::PH_OPEN;
          state_next.cand_mask = bpmp_pkg::ALL_TYPES;
          state_next.type_len  = 3'd0;
          state_next.cur_type  = 3'd0;
          value_length_next    = '0;
        end else if (too_long) begin
          state_next.phase = bpmp_pkg::PH_DISCARD;
        end else begin
          value_length_next = value_length + VLEN_W'(1);
        end
      end
      default: begin
        if (msg_byte == bpmp_pkg::CH_NUL) begin
          state_next.phase     = bpmp_pkg::PH_OPEN;
          state_next.cand_mask = bpmp_pkg::ALL_TYPES;
          state_next.type_len  = 3'd0;
          state_next.cur_type  = 3'd0;
          value_length_next    = '0;
        end
      end
    endcase
  end

  // result item
  always_comb begin
    result = '{status: bpmp_pkg::ST_NONE, data_byte: 8'h00, type_code: 3'd0,
               error_kind: bpmp_pkg::ERR_NONE};
    case (state.phase)
      bpmp_pkg::PH_OPEN: begin
        if (msg_byte == bpmp_pkg::CH_NUL) begin
          result.status = bpmp_pkg::ST_ACCEPT;
        end else if (msg_byte != bpmp_pkg::CH_OPEN) begin
          result.status     = bpmp_pkg::ST_REJECT;
          result.error_kind = bpmp_pkg::ERR_BRACE;
        end
      end
      bpmp_pkg::PH_TYPE: begin
        if (msg_byte == bpmp_pkg::CH_NUL) begin
          result.status     = bpmp_pkg::ST_REJECT;
          result.error_kind = bpmp_pkg::ERR_END;
        end else if (msg_byte == bpmp_pkg::CH_COLON && !found) begin
          result.status     = bpmp_pkg::ST_REJECT;
          result.error_kind = bpmp_pkg::ERR_TYPE;
        end
      end
      bpmp_pkg::PH_VALUE: begin
        if (msg_byte == bpmp_pkg::CH_NUL) begin
          result.status     = bpmp_pkg::ST_REJECT;
          result.error_kind = bpmp_pkg::ERR_END;
        end else if (msg_byte == bpmp_pkg::CH_CLOSE) begin
          result.status    = bpmp_pkg::ST_CLOSED;
          result.type_code = state.cur_type;
        end else if (too_long) begin
          result.status     = bpmp_pkg::ST_REJECT;
          result.error_kind = bpmp_pkg::ERR_LONG;
        end else begin
          result.status    = bpmp_pkg::ST_VALUE;
          result.data_byte = msg_byte;
          result.type_code = state.cur_type;
        end
      end
      default: begin
        result.status = bpmp_pkg::ST_NONE;
      end
    endcase
  end

endmodule

>>> rtl/brace_pair_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_pair_message_parser
// Parses {type:value} pairs from a byte stream, one result item per byte.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      accepted when
//  msg      in   msg_byte[7:0]                                valid && ready
//  res      out  status[2:0] data_byte[7:0] type_code[2:0]    valid && ready
//                error_kind[2:0]
//  cfg      in   value_limit[9:0]                             valid && ready
//
//  one item per cycle sustained while results are taken; a byte accepted into the
//  input register moves through the parser step into the result register, where
//  its result item is offered until the receiver takes it
//  the parser state updates when the input register moves to the result register
//  a stalled result holds both registers; msg stays ready while a slot is free
//  synchronous reset clears phase, pair state and valid flags, limit to 1023
//  cfg is always ready and writes the limit register at the end of the handshake cycle
// ----------------------------------------------------------------------------
module brace_pair_message_parser #(
  parameter int MAX_VALUE_LENGTH = 1023
) (
  input logic              clk,
  input logic              rst,
  bpmp_byte_if.sink        msg,
  bpmp_result_if.source    res,
  bpmp_cfg_if.sink         cfg
);

  localparam int LIM_CAP = (MAX_VALUE_LENGTH < 1023) ? MAX_VALUE_LENGTH : 1023;
  localparam int VLEN_W  = $clog2(LIM_CAP + 1);

  logic [9:0]            value_limit;
  logic [9:0]            limit;
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  out_free;
  logic                  advance;
  bpmp_pkg::pair_state_t state;
  bpmp_pkg::pair_state_t state_next;
  logic [VLEN_W-1:0]     value_length;
  logic [VLEN_W-1:0]     value_length_next;
  bpmp_pkg::result_t     result_next;
  bpmp_pkg::result_t     result;
  logic                  out_valid;

  // limit register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      value_limit <= bpmp_pkg::VALUE_LIMIT_RESET;
    end else if (cfg.valid) begin
      value_limit <= cfg.value_limit;
    end
  end

  assign limit = (value_limit > 10'(LIM_CAP)) ? 10'(LIM_CAP) : value_limit;

  // handshake
  assign out_free  = !out_valid || res.ready;
  assign advance   = in_valid && out_free;
  assign msg.ready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      in_byte <= msg.msg_byte;
    end
  end

  // parser step
  bpmp_core #(
    .VLEN_W (VLEN_W)
  ) u_core (
    .state             (state),
    .value_length      (value_length),
    .msg_byte          (in_byte),
    .limit             (limit),
    .state_next        (state_next),
    .value_length_next (value_length_next),
    .result            (result_next)
  );

  // pair state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '{phase: bpmp_pkg::PH_OPEN, cand_mask: bpmp_pkg::ALL_TYPES,
                        type_len: 3'd0, cur_type: 3'd0};
      value_length <= '0;
    end else if (advance) begin
      state        <= state_next;
      value_length <= value_length_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign res.valid      = out_valid;
  assign res.status     = result.status;
  assign res.data_byte  = result.data_byte;
  assign res.type_code  = result.type_code;
  assign res.error_kind = result.error_kind;

endmodule

>>> rtl/bpmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpmp_checker
// Port-level checks on the result channel of the brace pair message parser.
// ----------------------------------------------------------------------------
module bpmp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] data_byte,
  input logic [2:0] type_code,
  input logic [2:0] error_kind
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(error_kind))
    else $error("result dropped or changed while stalled");

  // error code present exactly on rejects
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_kind != bpmp_pkg::ERR_NONE) == (status == bpmp_pkg::ST_REJECT)))
    else $error("error code does not match reject status");

  // data only on value bytes
  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bpmp_pkg::ST_VALUE |-> data_byte == 8'h00)
    else $error("data byte outside a value item");

  // type code only on value bytes and closed pairs
  a_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bpmp_pkg::ST_VALUE && status != bpmp_pkg::ST_CLOSED
      |-> type_code == 3'd0)
    else $error("type code outside a pair item");

  // a value byte is never zero and never the closing brace
  a_vbyte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bpmp_pkg::ST_VALUE
      |-> data_byte != bpmp_pkg::CH_NUL && data_byte != bpmp_pkg::CH_CLOSE)
    else $error("framing character passed as value");

endmodule

bind brace_pair_message_parser bpmp_checker u_bpmp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .status     (res.status),
  .data_byte  (res.data_byte),
  .type_code  (res.type_code),
  .error_kind (res.error_kind)
);

>>> sim/brace_pair_message_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_pair_message_parser_tb
// Self-checking bench for the brace pair message parser. A short table of
// directed bytes comes first, then random messages: mostly well-formed
// pairs with random types and values, plus broken messages and noise. The
// value limit is rewritten between phases while the parser is idle. Each
// accepted byte is run through a local model of the parser, and every result
// item is compared field by field, in order, against the expected results.
// ----------------------------------------------------------------------------
module brace_pair_message_parser_tb;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_PHASES = 8;
  localparam int RUN_RANDOM_LIMIT = 4;
  localparam int PHASE_BYTES = 115;
  localparam int LONG_VALUE = 1024;
  localparam int NO_FORCE = -1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam logic [9:0] RUN_LIMIT [RUN_PHASES] = '{
    10'd1023, 10'd0, 10'd1, 10'd3, 10'd1023, 10'd7, 10'd1023, 10'd2
  };
  localparam idle_mode_t RUN_IDLE [RUN_PHASES] = '{
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH
  };

  // directed row: byte, and a typed expectation where one is given
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [2:0] st;
    logic [2:0] err;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty message after reset
    '{bpmp_pkg::CH_NUL,   1'b1, bpmp_pkg::ST_ACCEPT, bpmp_pkg::ERR_NONE},
    // no open brace, then discarded bytes up to the end of the message
    '{"x",                1'b1, bpmp_pkg::ST_REJECT, bpmp_pkg::ERR_BRACE},
    '{8'hFF,              1'b1, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_NUL,   1'b1, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    // use pair with top byte, open brace and colon inside the value
    '{bpmp_pkg::CH_OPEN,  1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{"u",                1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{"s",                1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{"e",                1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_COLON, 1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{8'hFF,              1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_OPEN,  1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_COLON, 1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{8'h01,              1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_CLOSE, 1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    // empty type
    '{bpmp_pkg::CH_OPEN,  1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_COLON, 1'b1, bpmp_pkg::ST_REJECT, bpmp_pkg::ERR_TYPE},
    '{bpmp_pkg::CH_NUL,   1'b1, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    // message ends inside the type, then ready again at once
    '{bpmp_pkg::CH_OPEN,  1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{"l",                1'b0, bpmp_pkg::ST_NONE,   bpmp_pkg::ERR_NONE},
    '{bpmp_pkg::CH_NUL,   1'b1, bpmp_pkg::ST_REJECT, bpmp_pkg::ERR_END},
    '{bpmp_pkg::CH_NUL,   1'b1, bpmp_pkg::ST_ACCEPT, bpmp_pkg::ERR_NONE}
  };

  logic clk;
  logic rst;

  bpmp_byte_if   msg_if ();
  bpmp_result_if res_if ();
  bpmp_cfg_if    cfg_if ();

  brace_pair_message_parser dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_if.sink),
    .res (res_if.source),
    .cfg (cfg_if.sink)
  );

  // parser model state
  bpmp_pkg::phase_t pp_phase;
  logic [4:0]       pp_mask;
  logic [2:0]       pp_tlen;
  logic [9:0]       pp_vlen;
  logic [2:0]       pp_type;
  logic [9:0]       pp_limit;

  bpmp_pkg::result_t expected_results [$];
  logic [7:0]        msg_buf [$];

  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles = 0;
  int n_bytes;
  int n_msgs;
  int n_fail;
  int n_value;
  int n_closed;
  int n_accept;
  int n_reject;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // clear the per-pair model state
  function automatic void clear_pair();
    pp_mask = bpmp_pkg::ALL_TYPES;
    pp_tlen = 3'd0;
    pp_vlen = 10'd0;
    pp_type = 3'd0;
  endfunction

  // model of one parser step: updates state, returns the result item
  function automatic bpmp_pkg::result_t predict_byte(input logic [7:0] b);
    bpmp_pkg::result_t r;
    logic [4:0]        m;
    logic              hit;
    r = '0;
    case (pp_phase)
      bpmp_pkg::PH_OPEN: begin
        clear_pair();
        if (b == bpmp_pkg::CH_NUL) begin
          r.status = bpmp_pkg::ST_ACCEPT;
        end else if (b == bpmp_pkg::CH_OPEN) begin
          pp_phase = bpmp_pkg::PH_TYPE;
        end else begin
          pp_phase = bpmp_pkg::PH_DISCARD;
          r.status = bpmp_pkg::ST_REJECT;
          r.error_kind = bpmp_pkg::ERR_BRACE;
        end
      end
      bpmp_pkg::PH_TYPE: begin
        if (b == bpmp_pkg::CH_NUL) begin
          pp_phase = bpmp_pkg::PH_OPEN;
          clear_pair();
          r.status = bpmp_pkg::ST_REJECT;
          r.error_kind = bpmp_pkg::ERR_END;
        end else if (b == bpmp_pkg::CH_COLON) begin
          // first candidate whose full length matches wins
          hit = 1'b0;
          for (int i = 0; i < bpmp_pkg::NUM_TYPES; i++) begin
            if (!hit && pp_mask[i] && bpmp_pkg::TYPE_LENS[i] == pp_tlen) begin
              hit = 1'b1;
              pp_type = 3'(i);
            end
          end
          if (hit) begin
            pp_phase = bpmp_pkg::PH_VALUE;
            pp_vlen = 10'd0;
          end else begin
            pp_phase = bpmp_pkg::PH_DISCARD;
            r.status = bpmp_pkg::ST_REJECT;
            r.error_kind = bpmp_pkg::ERR_TYPE;
          end
        end else begin
          // narrow the candidates by the character at this position
          m = 5'd0;
          for (int i = 0; i < bpmp_pkg::NUM_TYPES; i++) begin
            if (pp_mask[i] && pp_tlen < bpmp_pkg::TYPE_LENS[i] &&
                bpmp_pkg::NAME_CHARS[i][pp_tlen] == b) begin
              m[i] = 1'b1;
            end
          end
          pp_mask = m;
          if (pp_tlen < bpmp_pkg::TYPE_LEN_MAX) begin
            pp_tlen = pp_tlen + 3'd1;
          end
        end
      end
      bpmp_pkg::PH_VALUE: begin
        if (b == bpmp_pkg::CH_NUL) begin
          pp_phase = bpmp_pkg::PH_OPEN;
          clear_pair();
          r.status = bpmp_pkg::ST_REJECT;
          r.error_kind = bpmp_pkg::ERR_END;
        end else if (b == bpmp_pkg::CH_CLOSE) begin
          r.status = bpmp_pkg::ST_CLOSED;
          r.type_code = pp_type;
          pp_phase = bpmp_pkg::PH_OPEN;
          clear_pair();
        end else if (pp_vlen >= pp_limit) begin
          pp_phase = bpmp_pkg::PH_DISCARD;
          r.status = bpmp_pkg::ST_REJECT;
          r.error_kind = bpmp_pkg::ERR_LONG;
        end else begin
          pp_vlen = pp_vlen + 10'd1;
          r.status = bpmp_pkg::ST_VALUE;
          r.data_byte = b;
          r.type_code = pp_type;
        end
      end
      default: begin
        if (b == bpmp_pkg::CH_NUL) begin
          pp_phase = bpmp_pkg::PH_OPEN;
          clear_pair();
        end
      end
    endcase
    return r;
  endfunction

  // random nonzero byte other than one framing character
  function automatic logic [7:0] rand_char_except(input logic [7:0] ex);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == ex);
    return c;
  endfunction

  // append one byte to the message being built
  function automatic void put_byte(input logic [7:0] b);
    msg_buf = {msg_buf, b};
  endfunction

  // build one random message into msg_buf; force_len forces one long value
  function automatic void build_message(input int force_len);
    logic [7:0] nm [$];
    int         kind;
    int         npairs;
    int         t;
    int         sel;
    int         vl;
    int         pos;
    msg_buf.delete();
    kind = (force_len >= 0) ? 0 : $urandom_range(0, 99);
    if (kind >= 85) begin
      // noise, may hold zero bytes anywhere
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
      put_byte(bpmp_pkg::CH_NUL);
      return;
    end
    npairs = (force_len >= 0) ? 1 : $urandom_range(0, 3);
    repeat (npairs) begin
      put_byte(bpmp_pkg::CH_OPEN);
      // type: mostly a real name, some near misses, some junk
      t = (force_len >= 0) ? 3 : $urandom_range(0, bpmp_pkg::NUM_TYPES - 1);
      sel = (force_len >= 0) ? 0 : $urandom_range(0, 99);
      nm.delete();
      for (int k = 0; k < bpmp_pkg::TYPE_LENS[t]; k++) nm = {nm, bpmp_pkg::NAME_CHARS[t][k]};
      if (sel >= 93) begin
        nm.delete();
        repeat ($urandom_range(0, 9)) nm = {nm, rand_char_except(bpmp_pkg::CH_COLON)};
      end else if (sel >= 85) begin
        case ($urandom_range(0, 2))
          0: void'(nm.pop_back());
          1: repeat ($urandom_range(1, 3)) nm = {nm, 8'($urandom_range(97, 122))};
          default: nm[$urandom_range(0, nm.size() - 1)] = 8'($urandom_range(97, 122));
        endcase
      end
      foreach (nm[k]) put_byte(nm[k]);
      put_byte(bpmp_pkg::CH_COLON);
      // value length around the limit when it is small
      if (force_len >= 0) begin
        vl = force_len;
      end else if (pp_limit <= 10'd12) begin
        vl = $urandom_range(0, int'(pp_limit) + 2);
      end else if ($urandom_range(0, 19) == 0) begin
        vl = $urandom_range(0, 40);
      end else begin
        vl = $urandom_range(0, 8);
      end
      repeat (vl) put_byte(rand_char_except(bpmp_pkg::CH_CLOSE));
      put_byte(bpmp_pkg::CH_CLOSE);
    end
    put_byte(bpmp_pkg::CH_NUL);
    // broken message: corrupt a byte or cut it short
    if (kind >= 70) begin
      pos = $urandom_range(0, msg_buf.size() - 1);
      if ($urandom_range(0, 1) == 0) begin
        msg_buf[pos] = 8'($urandom_range(0, 255));
      end else begin
        msg_buf = msg_buf[0:pos];
        put_byte(bpmp_pkg::CH_NUL);
      end
    end
  endfunction

  // send one byte item; valid stays high afterwards unless a gap follows
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input bpmp_pkg::result_t typed_exp);
    bpmp_pkg::result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk);
    end
    msg_if.valid <= 1'b1;
    msg_if.msg_byte <= b;
    do @(posedge clk); while (!msg_if.ready);
    pred = predict_byte(b);
    if (typed) begin
      pred = typed_exp;
    end
    expected_results = {expected_results, pred};
    n_bytes++;
  endtask

  // stop sending and wait for every expected result
  task automatic drain_results();
    msg_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // write the value limit while the parser is idle
  task automatic write_limit(input logic [9:0] v);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.value_limit <= v;
    do @(posedge clk); while (!cfg_if.ready);
    pp_limit = v;
    cfg_if.valid <= 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    bpmp_pkg::result_t got;
    bpmp_pkg::result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{res_if.status, res_if.data_byte, res_if.type_code, res_if.error_kind};
      case (got.status)
        bpmp_pkg::ST_VALUE:  n_value++;
        bpmp_pkg::ST_CLOSED: n_closed++;
        bpmp_pkg::ST_ACCEPT: n_accept++;
        bpmp_pkg::ST_REJECT: n_reject++;
        default: ;
      endcase
      if (expected_results.size() == 0) begin
        if (n_fail < MAX_REPORTS) begin
          $display("unexpected result: status %0d data %02h type %0d err %0d",
                   got.status, got.data_byte, got.type_code, got.error_kind);
        end
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status || got.data_byte != want.data_byte ||
            got.type_code != want.type_code || got.error_kind != want.error_kind) begin
          if (n_fail < MAX_REPORTS) begin
            $display("mismatch: expected status %0d data %02h type %0d err %0d",
                     want.status, want.data_byte, want.type_code, want.error_kind);
            $display("          got      status %0d data %02h type %0d err %0d",
                     got.status, got.data_byte, got.type_code, got.error_kind);
          end
          n_fail++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [9:0] lim;
    int         phase_end;
    logic       long_done;
    rst = 1'b1;
    msg_if.valid = 1'b0;
    msg_if.msg_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.value_limit = 10'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_bytes = 0;
    n_msgs = 0;
    n_fail = 0;
    n_value = 0;
    n_closed = 0;
    n_accept = 0;
    n_reject = 0;
    long_done = 1'b0;
    pp_phase = bpmp_pkg::PH_OPEN;
    pp_limit = bpmp_pkg::VALUE_LIMIT_RESET;
    clear_pair();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TAB[i].b, DIR_TAB[i].typed,
                bpmp_pkg::result_t'{DIR_TAB[i].st, 8'h00, 3'd0, DIR_TAB[i].err});
    end

    // random phases, each with its own limit and idling pattern
    for (int p = 0; p < RUN_PHASES; p++) begin
      lim = (p == RUN_RANDOM_LIMIT) ? 10'($urandom_range(1, 1023)) : RUN_LIMIT[p];
      write_limit(lim);
      case (RUN_IDLE[p])
        IDLE_SEND: begin send_idle_pct = 62; recv_stall_pct = 0; end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        IDLE_BOTH: begin send_idle_pct = 6;  recv_stall_pct = 6; end
        default:   begin send_idle_pct = 0;  recv_stall_pct = 0; end
      endcase
      phase_end = n_bytes + PHASE_BYTES;
      while (n_bytes < phase_end) begin
        // one value just past the widest limit
        if (!long_done && lim == bpmp_pkg::VALUE_LIMIT_RESET) begin
          build_message(LONG_VALUE);
          long_done = 1'b1;
        end else begin
          build_message(NO_FORCE);
        end
        foreach (msg_buf[k]) send_byte(msg_buf[k], 1'b0, '0);
        n_msgs++;
        if ($urandom_range(0, 14) == 0) drain_results();
      end
    end

    // wind down
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      n_fail += expected_results.size();
    end
    $display("sent %0d bytes in %0d random messages over %0d limit settings",
             n_bytes, n_msgs, RUN_PHASES);
    $display("saw %0d value bytes, %0d closed pairs, %0d accepts, %0d rejects; %0d errors",
             n_value, n_closed, n_accept, n_reject, n_fail);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
